FILE: rtl/intel_hex_record_writer_defines.svh
// Assertion macros shared by the Intel HEX writer RTL.
// Each macro expects signals clk and arst_n in the including scope.
`ifndef INTEL_HEX_RECORD_WRITER_DEFINES_SVH
`define INTEL_HEX_RECORD_WRITER_DEFINES_SVH

// Condition must hold at every edge out of reset.
`define IHEXW_ASSERT_HOLDS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define IHEXW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define IHEXW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ihexw_pkg.sv
// Package for the Intel HEX record writer: sizes, record codes, job types.
// No dependencies; used by every module of the block but the RAM.
`default_nettype none

package ihexw_pkg;

	localparam int RECORD_BYTES = 16;            // bytes per data record, 1..16
	localparam int LINE_DEPTH   = 16;
	localparam int NUM_BANKS    = 2;              // line buffer is double banked
	localparam int BUF_DEPTH    = LINE_DEPTH * NUM_BANKS;
	localparam int BUF_AW       = $clog2(BUF_DEPTH);
	localparam int IDX_W        = $clog2(LINE_DEPTH);
	localparam int CNT_W        = 5;

	localparam logic [7:0] RT_DATA = 8'h00;
	localparam logic [7:0] RT_EOF  = 8'h01;

	localparam logic [6:0] CH_COLON = 7'h3A;
	localparam logic [6:0] CH_LF    = 7'h0A;

	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_END  = 1'b1;

	// One record job handed from front to back.
	typedef struct packed {
		logic             has_data;  // emit a data record from the bank
		logic             has_end;   // follow with the end-of-file record
		logic [CNT_W-1:0] count;
		logic [15:0]      addr;
		logic             bank;
	} job_t;

	// Back tells front a bank may be refilled.
	typedef struct packed {
		logic valid;
		logic bank;
	} release_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_COLON,
		B_HEAD,
		B_DATA,
		B_SUM,
		B_LF
	} back_state_t;

	function automatic logic [6:0] hex_ascii(input logic [3:0] nib);
		logic [6:0] n7;
		n7 = {3'b000, nib};
		return (nib < 4'd10) ? (7'h30 + n7) : (7'h37 + n7);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/intel_hex_record_writer.sv
// Top level of the Intel HEX record writer: front end, job queue, back end
// and the double-banked line buffer RAM. Uses ihexw_pkg.
`default_nettype none

// Raw bytes go in on the src channel, one per cycle while the front end has
// room; a byte that completes a 16-byte line posts a data record, and an end
// command posts the flush of any partial line plus the end-of-file record.
// Text comes out on the dst channel one ASCII character per cycle while
// dst_stall is low, from the back-end sequencer: a data record of n bytes
// takes 12 + 2n characters, so a steady byte stream is limited by the
// character output. Lines are held in two buffer banks and up to two record
// jobs queue between the halves; the input stalls while both banks wait to
// be printed or while two jobs wait in the queue. last_of_run marks the line
// feed that ends the text caused by one input item.
module intel_hex_record_writer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	output logic       src_stall,
	input  logic       command,
	input  logic [7:0] data_byte,
	output logic       dst_valid,
	input  logic       dst_stall,
	output logic [6:0] text_char,
	output logic       last_of_run
);
	import ihexw_pkg::*;

	logic              buf_we;
	logic [BUF_AW-1:0] buf_waddr;
	logic [7:0]        buf_wdata;
	logic              buf_re;
	logic [BUF_AW-1:0] buf_raddr;
	logic [7:0]        buf_rdata;
	logic              push;
	job_t              push_job;
	logic              q_full;
	logic              q_pop;
	logic              q_valid;
	job_t              q_head;
	release_t          rel;

	ihexw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.command   (command),
		.data_byte (data_byte),
		.buf_we    (buf_we),
		.buf_waddr (buf_waddr),
		.buf_wdata (buf_wdata),
		.push      (push),
		.push_job  (push_job),
		.q_full    (q_full),
		.rel       (rel)
	);

	ihexw_jobq u_jobq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	ihexw_ram #(
		.WIDTH (8),
		.DEPTH (BUF_DEPTH)
	) u_line_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wdata (buf_wdata),
		.re    (buf_re),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	ihexw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.buf_re      (buf_re),
		.buf_raddr   (buf_raddr),
		.buf_rdata   (buf_rdata),
		.rel         (rel),
		.dst_valid   (dst_valid),
		.dst_stall   (dst_stall),
		.text_char   (text_char),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire

FILE: rtl/ihexw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ihexw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/ihexw_front.sv
// Front end: accepts bytes and end commands, fills the line buffer banks,
// tracks the running address and posts record jobs. Uses ihexw_pkg.
`default_nettype none
`include "intel_hex_record_writer_defines.svh"

module ihexw_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          src_valid,
	output logic                          src_stall,
	input  logic                          command,
	input  logic [7:0]                    data_byte,
	output logic                          buf_we,
	output logic [ihexw_pkg::BUF_AW-1:0]  buf_waddr,
	output logic [7:0]                    buf_wdata,
	output logic                          push,
	output ihexw_pkg::job_t               push_job,
	input  logic                          q_full,
	input  ihexw_pkg::release_t           rel
);
	import ihexw_pkg::*;

	logic [CNT_W-1:0]     fill_q;
	logic [15:0]          addr_q;
	logic                 cur_bank_q;
	logic [NUM_BANKS-1:0] bank_pend_q;

	logic             acc;
	logic [CNT_W-1:0] fill_inc;
	logic             line_full;
	logic             swap;

	assign src_stall = q_full | bank_pend_q[cur_bank_q];
	assign acc       = src_valid & ~src_stall;
	assign fill_inc  = fill_q + CNT_W'(1);
	assign line_full = (fill_inc == CNT_W'(RECORD_BYTES));

	assign buf_we    = acc & (command == CMD_DATA);
	assign buf_waddr = {cur_bank_q, fill_q[IDX_W-1:0]};
	assign buf_wdata = data_byte;

	always_comb begin
		push              = acc & ((command == CMD_END) | line_full);
		push_job.has_data = (command == CMD_END) ? (fill_q != '0) : 1'b1;
		push_job.has_end  = (command == CMD_END);
		push_job.count    = (command == CMD_END) ? fill_q : fill_inc;
		// address of first byte in the line
		push_job.addr     = addr_q - 16'(fill_q);
		push_job.bank     = cur_bank_q;
	end

	assign swap = push & push_job.has_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			addr_q      <= '0;
			cur_bank_q  <= 1'b0;
			bank_pend_q <= '0;
		end else begin
			if (acc) begin
				if (command == CMD_END) begin
					fill_q <= '0;
					addr_q <= '0;
				end else begin
					addr_q <= addr_q + 16'd1;
					fill_q <= line_full ? '0 : fill_inc;
				end
			end
			if (swap) begin
				cur_bank_q <= ~cur_bank_q;
			end
			for (int b = 0; b < NUM_BANKS; b++) begin
				if (swap && cur_bank_q == 1'(b)) begin
					bank_pend_q[b] <= 1'b1;
				end else if (rel.valid && rel.bank == 1'(b)) begin
					bank_pend_q[b] <= 1'b0;
				end
			end
		end
	end

	`IHEXW_ASSERT_IMP(a_wr_free_bank, buf_we, !bank_pend_q[cur_bank_q], "write into busy bank")
	`IHEXW_ASSERT_HOLDS(a_fill_range, fill_q < CNT_W'(RECORD_BYTES), "fill count overran line")
	`IHEXW_ASSERT_NEXT(a_pend_set, swap, bank_pend_q[$past(cur_bank_q)], "posted bank not held")

endmodule

`default_nettype wire

FILE: rtl/ihexw_jobq.sv
// Two-entry job queue between front and back ends.
// Uses ihexw_pkg for the job type.
`default_nettype none

module ihexw_jobq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ihexw_pkg::job_t push_job,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output ihexw_pkg::job_t head
);
	import ihexw_pkg::*;

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/ihexw_back.sv
// Back end: character sequencer that turns record jobs into HEX text,
// with the output register. Uses ihexw_pkg and reads the line buffer.
`default_nettype none
`include "intel_hex_record_writer_defines.svh"

module ihexw_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  ihexw_pkg::job_t               q_head,
	output logic                          q_pop,
	output logic                          buf_re,
	output logic [ihexw_pkg::BUF_AW-1:0]  buf_raddr,
	input  logic [7:0]                    buf_rdata,
	output ihexw_pkg::release_t           rel,
	output logic                          dst_valid,
	input  logic                          dst_stall,
	output logic [6:0]                    text_char,
	output logic                          last_of_run
);
	import ihexw_pkg::*;

	back_state_t      state_q, state_n;
	job_t             job_q, job_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [15:0]      raddr_q, raddr_n;
	logic             rec_end_q, rec_end_n;
	logic [2:0]       digit_q, digit_n;
	logic [IDX_W-1:0] idx_q, idx_n;
	logic [7:0]       sum_q, sum_n;

	logic       out_valid_q;
	logic [6:0] text_q;
	logic       last_q;

	logic       adv;
	logic       emit;
	logic [6:0] ch;
	logic       last;
	logic [31:0] hdr;
	logic [3:0] hnib;
	logic [7:0] chk;
	logic       job_done;

	assign adv = ~out_valid_q | ~dst_stall;
	assign hdr = {3'b000, cnt_q, raddr_q, (rec_end_q ? RT_EOF : RT_DATA)};
	assign hnib = 4'(hdr >> {~digit_q, 2'b00});
	assign chk = 8'd0 - sum_q;
	assign job_done = rec_end_q | ~job_q.has_end;

	always_comb begin
		state_n   = state_q;
		job_n     = job_q;
		cnt_n     = cnt_q;
		raddr_n   = raddr_q;
		rec_end_n = rec_end_q;
		digit_n   = digit_q;
		idx_n     = idx_q;
		sum_n     = sum_q;
		q_pop     = 1'b0;
		buf_re    = 1'b0;
		buf_raddr = {job_q.bank, idx_q};
		rel       = '0;
		emit      = 1'b0;
		ch        = CH_LF;
		last      = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					job_n   = q_head;
					state_n = B_COLON;
					if (q_head.has_data) begin
						cnt_n     = q_head.count;
						raddr_n   = q_head.addr;
						rec_end_n = 1'b0;
						sum_n     = 8'(q_head.count) + q_head.addr[15:8] + q_head.addr[7:0];
					end else begin
						cnt_n     = '0;
						raddr_n   = '0;
						rec_end_n = 1'b1;
						sum_n     = RT_EOF;
					end
				end
			end
			B_COLON: begin
				emit = 1'b1;
				ch   = CH_COLON;
				if (adv) begin
					state_n = B_HEAD;
					digit_n = '0;
				end
			end
			B_HEAD: begin
				emit = 1'b1;
				ch   = hex_ascii(hnib);
				if (adv) begin
					digit_n = digit_q + 3'd1;
					if (digit_q == 3'd7) begin
						digit_n = '0;
						if (cnt_q != '0) begin
							// prefetch first data byte
							state_n   = B_DATA;
							idx_n     = '0;
							buf_re    = 1'b1;
							buf_raddr = {job_q.bank, {IDX_W{1'b0}}};
						end else begin
							state_n = B_SUM;
						end
					end
				end
			end
			B_DATA: begin
				emit = 1'b1;
				ch   = hex_ascii(digit_q[0] ? buf_rdata[3:0] : buf_rdata[7:4]);
				if (adv) begin
					if (!digit_q[0]) begin
						digit_n = 3'd1;
					end else begin
						digit_n = '0;
						sum_n   = sum_q + buf_rdata;
						if (CNT_W'(idx_q) + CNT_W'(1) == cnt_q) begin
							state_n = B_SUM;
						end else begin
							idx_n     = idx_q + IDX_W'(1);
							buf_re    = 1'b1;
							buf_raddr = {job_q.bank, idx_q + IDX_W'(1)};
						end
					end
				end
			end
			B_SUM: begin
				emit = 1'b1;
				ch   = hex_ascii(digit_q[0] ? chk[3:0] : chk[7:4]);
				if (adv) begin
					if (!digit_q[0]) begin
						digit_n = 3'd1;
					end else begin
						digit_n = '0;
						state_n = B_LF;
					end
				end
			end
			B_LF: begin
				emit = 1'b1;
				ch   = CH_LF;
				last = job_done;
				if (adv) begin
					if (job_done) begin
						state_n   = B_IDLE;
						rel.valid = job_q.has_data;
						rel.bank  = job_q.bank;
					end else begin
						// end-of-file record follows the flushed line
						state_n   = B_COLON;
						cnt_n     = '0;
						raddr_n   = '0;
						rec_end_n = 1'b1;
						sum_n     = RT_EOF;
					end
				end
			end
			default: begin
				state_n = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (adv) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		job_q     <= job_n;
		cnt_q     <= cnt_n;
		raddr_q   <= raddr_n;
		rec_end_q <= rec_end_n;
		digit_q   <= digit_n;
		idx_q     <= idx_n;
		sum_q     <= sum_n;
		if (adv) begin
			text_q <= ch;
			last_q <= last;
		end
	end

	assign dst_valid   = out_valid_q;
	assign text_char   = text_q;
	assign last_of_run = last_q;

	`IHEXW_ASSERT_IMP(a_data_idx, state_q == B_DATA, CNT_W'(idx_q) < cnt_q, "data index past count")
	`IHEXW_ASSERT_IMP(a_last_is_lf, out_valid_q && last_q, text_q == CH_LF, "run ends off a line feed")
	`IHEXW_ASSERT_NEXT(a_eof_follows, state_q == B_LF && adv && !job_done, state_q == B_COLON && rec_end_q, "end record missing after flush")
	`IHEXW_ASSERT_IMP(a_pop_idle, q_pop, state_q == B_IDLE, "job taken while busy")

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for intel_hex_record_writer: byte stream in, Intel HEX text out.
// Expected text: behavioral encoder here or typed-in text. Uses ihexw_pkg and the DUT.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ihexw_pkg::*;

	typedef struct {
		logic [6:0] ch;
		logic       last;
	} text_sym_t;

	typedef struct {
		logic       cmd;
		logic [7:0] value;
		string      text;     // typed-in text, empty when the encoder decides
	} script_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       src_valid;
	logic       src_stall;
	logic       command;
	logic [7:0] data_byte;
	logic       dst_valid;
	logic       dst_stall;
	logic [6:0] text_char;
	logic       last_of_run;

	// encoder state
	logic [7:0]  line_bytes [LINE_DEPTH];
	int unsigned line_fill;
	logic [15:0] stream_addr;

	text_sym_t item_text[$];
	text_sym_t pending_text[$];
	int        mismatch_count = 0;
	logic      quiet_phase = 1'b0;
	logic      hold_request = 1'b0;
	int        hold_left = 0;

	script_row_t directed_rows[$] = '{
		'{CMD_END,  8'h00, ":00000001FF\n"},
		'{CMD_DATA, 8'hFF, ""},
		'{CMD_END,  8'h00, ":01000000FF00\n:00000001FF\n"},
		'{CMD_DATA, 8'h00, ""}, '{CMD_DATA, 8'hFF, ""}, '{CMD_DATA, 8'h01, ""},
		'{CMD_DATA, 8'h80, ""}, '{CMD_DATA, 8'h7F, ""}, '{CMD_DATA, 8'hFE, ""},
		'{CMD_DATA, 8'h55, ""}, '{CMD_DATA, 8'hAA, ""}, '{CMD_DATA, 8'h0F, ""},
		'{CMD_DATA, 8'hF0, ""}, '{CMD_DATA, 8'h12, ""}, '{CMD_DATA, 8'h34, ""},
		'{CMD_DATA, 8'h9C, ""}, '{CMD_DATA, 8'hE1, ""}, '{CMD_DATA, 8'h3B, ""},
		'{CMD_DATA, 8'hC6, ""},
		'{CMD_DATA, 8'h00, ""}, '{CMD_DATA, 8'h00, ""},
		'{CMD_END,  8'h00, ""},
		'{CMD_END,  8'h00, ":00000001FF\n"}
	};

	intel_hex_record_writer DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.src_valid  (src_valid),
		.src_stall  (src_stall),
		.command    (command),
		.data_byte  (data_byte),
		.dst_valid  (dst_valid),
		.dst_stall  (dst_stall),
		.text_char  (text_char),
		.last_of_run(last_of_run)
	);

	always #2 clk = ~clk;

	function automatic void put_char(logic [6:0] c);
		item_text.push_back(text_sym_t'{c, 1'b0});
	endfunction

	function automatic void put_hex(logic [7:0] v);
		logic [3:0] nib;
		for (int k = 1; k >= 0; k--) begin
			nib = v[k*4 +: 4];
			if (nib < 4'd10)
				put_char(7'("0") + 7'(nib));
			else
				put_char(7'("A") + 7'(nib) - 7'd10);
		end
	endfunction

	function automatic void put_record(int unsigned count, logic [15:0] addr, logic [7:0] rtype);
		logic [7:0] sum;
		sum = 8'(count) + addr[15:8] + addr[7:0] + rtype;
		put_char(CH_COLON);
		put_hex(8'(count));
		put_hex(addr[15:8]);
		put_hex(addr[7:0]);
		put_hex(rtype);
		for (int k = 0; k < int'(count); k++) begin
			sum = sum + line_bytes[k];
			put_hex(line_bytes[k]);
		end
		put_hex(8'h00 - sum);
		put_char(CH_LF);
	endfunction

	// Text caused by one accepted item; leaves it in item_text.
	function automatic void encode_item(logic cmd, logic [7:0] value);
		item_text.delete();
		if (cmd == CMD_DATA) begin
			line_bytes[line_fill] = value;
			line_fill++;
			stream_addr++;
			if (line_fill == RECORD_BYTES) begin
				put_record(line_fill, stream_addr - 16'(line_fill), RT_DATA);
				line_fill = 0;
			end
		end else begin
			if (line_fill != 0)
				put_record(line_fill, stream_addr - 16'(line_fill), RT_DATA);
			put_record(0, 16'h0000, RT_EOF);
			line_fill = 0;
			stream_addr = 16'h0000;
		end
		if (item_text.size() > 0)
			item_text[item_text.size()-1].last = 1'b1;
	endfunction

	task automatic offer(logic cmd, logic [7:0] value, string text);
		bit gapped;
		gapped = 1'b0;
		while (!quiet_phase && hold_left == 0 && $urandom_range(0, 99) < 22) begin
			if (!gapped)
				src_valid <= 1'b0;
			gapped = 1'b1;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		command <= cmd;
		data_byte <= value;
		do
			@(posedge clk);
		while (src_stall);
		encode_item(cmd, value);
		if (text != "") begin
			item_text.delete();
			for (int k = 0; k < text.len(); k++)
				put_char(7'(text[k]));
			item_text[item_text.size()-1].last = 1'b1;
		end
		foreach (item_text[k])
			pending_text.push_back(item_text[k]);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// stimulus
	initial begin
		arst_n <= 1'b0;
		src_valid <= 1'b0;
		command <= CMD_DATA;
		data_byte <= 8'h00;
		line_fill = 0;
		stream_addr = 16'h0000;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].text);

		for (int i = 0; i < 200; i++) begin
			quiet_phase = (i >= 40 && i < 100);
			if (i == 130)
				hold_request = 1'b1;
			if ($urandom_range(0, 19) == 0)
				offer(CMD_END, 8'($urandom), "");
			else
				offer(CMD_DATA, pick_byte(), "");
		end
		offer(CMD_END, 8'h00, "");

		src_valid <= 1'b0;
		while (pending_text.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatch_count == 0 && pending_text.size() == 0) begin
			$display("No mismatches found");
		end else begin
			if (pending_text.size() != 0)
				$error("%0d expected characters never arrived", pending_text.size());
			$display("Mismatches found");
		end
		$finish;
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		dst_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 300;
			end
			if (hold_left != 0) begin
				dst_stall <= 1'b1;
				hold_left--;
			end else begin
				dst_stall <= !quiet_phase && ($urandom_range(0, 99) < 22);
			end
		end
	end

	// output check, one transfer per edge
	always @(posedge clk) begin
		text_sym_t want;
		if (arst_n && dst_valid && !dst_stall) begin
			if (pending_text.size() == 0) begin
				$error("unexpected transfer: text_char %h last_of_run %b",
					text_char, last_of_run);
				mismatch_count++;
			end else begin
				want = pending_text.pop_front();
				if (text_char !== want.ch) begin
					$error("text_char: expected %h actual %h", want.ch, text_char);
					mismatch_count++;
				end
				if (last_of_run !== want.last) begin
					$error("last_of_run: expected %b actual %b", want.last, last_of_run);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#8_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/ihexw_pkg.sv
rtl/ihexw_ram.sv
rtl/ihexw_front.sv
rtl/ihexw_jobq.sv
rtl/ihexw_back.sv
rtl/intel_hex_record_writer.sv
tb/testbench.sv
